// ===== sv/lprd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprd_pkg
// Shared types and constants of the length-prefixed request deframer.
// ----------------------------------------------------------------------------
package lprd_pkg;

  localparam int LENGTH_BITS_DEF = 16;
  localparam int CFG_INDEX_W     = 8;
  localparam int HDR_BYTES       = 4;
  localparam int HDR_SHIFT_W     = 24;

  localparam logic [15:0] MAX_MSG_LEN_RST = 16'd4096;
  localparam logic [15:0] MAX_ARG_CNT_RST = 16'd1024;

  localparam logic [CFG_INDEX_W-1:0] REG_MAX_MSG_LEN = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ARG_CNT = CFG_INDEX_W'(1);

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_EMPTY  = 2'd1,
    KIND_NOARGS = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    CAUSE_NONE     = 3'd0,
    CAUSE_TOO_LONG = 3'd1,
    CAUSE_SHORT    = 3'd2,
    CAUSE_ARGS     = 3'd3,
    CAUSE_HDR_OVR  = 3'd4,
    CAUSE_DATA_OVR = 3'd5,
    CAUSE_TRAIL    = 3'd6
  } cause_t;

  typedef struct packed {
    logic [15:0] max_msg_len;
    logic [15:0] max_arg_cnt;
  } limits_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  arg_byte;
    logic [15:0] arg_index;
    logic        last_arg;
    logic        last_msg;
    cause_t      cause;
  } result_t;

endpackage

// ===== sv/length_prefixed_request_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_request_deframer
// Splits a length-prefixed request byte stream into tagged argument bytes.
// An accepted byte is held in an input register; its result, if any, is registered in the parser's result stage.
// One byte is accepted per cycle, limited only by the output stall.
// Reset is synchronous; limits return to 4096 and 1024 bytes/arguments.
// A protocol error stops result generation until the next reset.
// ----------------------------------------------------------------------------
module length_prefixed_request_deframer import lprd_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_stream_byte,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             out_kind,
  output logic [7:0]             out_arg_byte,
  output logic [15:0]            out_arg_index,
  output logic                   out_last_of_argument,
  output logic                   out_last_of_message,
  output logic [2:0]             out_error_cause
);

  limits_t    limits;
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       advance;
  logic       step_en;
  result_t    res;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign in_ready  = !in_vld_r || advance;
  assign step_en   = in_vld_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_stream_byte;
    end
  end

  lprd_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .limits   (limits)
  );

  lprd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .step_byte (in_byte_r),
    .limits    (limits),
    .res_ready (out_ready),
    .res_valid (out_valid),
    .res       (res)
  );

  assign out_kind             = res.kind;
  assign out_arg_byte         = res.arg_byte;
  assign out_arg_index        = res.arg_index;
  assign out_last_of_argument = res.last_arg;
  assign out_last_of_message  = res.last_msg;
  assign out_error_cause      = res.cause;

  a_error_ends_message: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ERROR |-> out_last_of_message && !out_last_of_argument)
    else $error("error transaction without end-of-message mark");

  a_cause_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_kind == KIND_ERROR) == (out_error_cause != CAUSE_NONE)))
    else $error("error cause disagrees with kind");

  a_silent_after_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_kind == KIND_ERROR |=> !out_valid)
    else $error("transaction produced after a protocol error");

  a_noargs_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_NOARGS |-> out_arg_index == 16'd0 && out_last_of_message)
    else $error("malformed empty-message transaction");

endmodule

// ===== sv/lprd_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprd_cfg_regs
// Limit registers written through the configuration channel.
// ----------------------------------------------------------------------------
module lprd_cfg_regs import lprd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [15:0]            wr_data,
  output limits_t                limits
);

  logic [15:0] max_msg_len_r;
  logic [15:0] max_arg_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_msg_len_r <= MAX_MSG_LEN_RST;
      max_arg_cnt_r <= MAX_ARG_CNT_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MAX_MSG_LEN: max_msg_len_r <= wr_data;
        REG_MAX_ARG_CNT: max_arg_cnt_r <= wr_data;
        default: ;
      endcase
    end
  end

  assign limits.max_msg_len = max_msg_len_r;
  assign limits.max_arg_cnt = max_arg_cnt_r;

endmodule

// ===== sv/lprd_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprd_parser
// Per-byte framing state machine with the registered result stage.
// ----------------------------------------------------------------------------
module lprd_parser import lprd_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] step_byte,
  input  limits_t    limits,
  input  logic       res_ready,
  output logic       res_valid,
  output result_t    res
);

  localparam logic [31:0] LEN_MASK = 32'((64'd1 << LENGTH_BITS) - 64'd1);
  localparam logic [LENGTH_BITS-1:0] HDR_LEN = LENGTH_BITS'(HDR_BYTES);

  typedef enum logic [2:0] {
    PH_LEN    = 3'd0,
    PH_COUNT  = 3'd1,
    PH_ARGLEN = 3'd2,
    PH_DATA   = 3'd3,
    PH_DEAD   = 3'd4
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [1:0]             hdr_cnt_r, hdr_cnt_nxt;
  logic [HDR_SHIFT_W-1:0] hdr_shift_r, hdr_shift_nxt;
  logic [LENGTH_BITS-1:0] body_len_r, body_len_nxt;
  logic [LENGTH_BITS-1:0] body_pos_r, body_pos_nxt;
  logic [15:0]            args_r, args_nxt;
  logic [LENGTH_BITS-1:0] bytes_r, bytes_nxt;
  logic [15:0]            idx_r, idx_nxt;
  logic                   res_vld_r;
  result_t                res_r, res_nxt;
  logic                   emit;

  logic [LENGTH_BITS-1:0] pos_inc;
  logic [LENGTH_BITS-1:0] body_rem;
  logic [LENGTH_BITS-1:0] bytes_dec;
  logic [15:0]            args_dec;
  logic [31:0]            word;
  logic [31:0]            len_limit;
  logic                   hdr_done;
  logic                   fail;
  cause_t                 fail_cause;
  logic                   arg_end;
  kind_t                  end_kind;
  logic [7:0]             end_byte;
  logic [15:0]            end_args;

  always_comb begin
    pos_inc   = body_pos_r + LENGTH_BITS'(1);
    body_rem  = body_len_r - pos_inc;
    bytes_dec = (bytes_r != '0) ? bytes_r - LENGTH_BITS'(1) : bytes_r;
    args_dec  = (args_r != 16'd0) ? args_r - 16'd1 : args_r;
    word      = {step_byte, hdr_shift_r};
    hdr_done  = (hdr_cnt_r == 2'd3);
    len_limit = (32'(limits.max_msg_len) < LEN_MASK) ? 32'(limits.max_msg_len) : LEN_MASK;

    phase_nxt     = phase_r;
    hdr_cnt_nxt   = hdr_cnt_r;
    hdr_shift_nxt = hdr_shift_r;
    body_len_nxt  = body_len_r;
    body_pos_nxt  = body_pos_r;
    args_nxt      = args_r;
    bytes_nxt     = bytes_r;
    idx_nxt       = idx_r;
    emit          = 1'b0;
    res_nxt       = '0;
    fail          = 1'b0;
    fail_cause    = CAUSE_NONE;
    arg_end       = 1'b0;
    end_kind      = KIND_BYTE;
    end_byte      = 8'd0;
    end_args      = args_r;

    if (phase_r == PH_LEN || phase_r == PH_COUNT || phase_r == PH_ARGLEN) begin
      hdr_cnt_nxt = hdr_cnt_r + 2'd1;
      if (hdr_cnt_r == 2'd0) begin
        hdr_shift_nxt = HDR_SHIFT_W'(step_byte);
      end else begin
        hdr_shift_nxt = hdr_shift_r | (HDR_SHIFT_W'(step_byte) << {hdr_cnt_r, 3'b000});
      end
    end

    unique case (phase_r)
      PH_LEN: begin
        if (hdr_done) begin
          if (word > len_limit) begin
            fail       = 1'b1;
            fail_cause = CAUSE_TOO_LONG;
          end else if (word < 32'(HDR_BYTES)) begin
            fail       = 1'b1;
            fail_cause = CAUSE_SHORT;
          end else begin
            body_len_nxt = word[LENGTH_BITS-1:0];
            body_pos_nxt = '0;
            phase_nxt    = PH_COUNT;
          end
        end
      end
      PH_COUNT: begin
        body_pos_nxt = pos_inc;
        if (hdr_done) begin
          if (word > 32'(limits.max_arg_cnt)) begin
            fail       = 1'b1;
            fail_cause = CAUSE_ARGS;
          end else begin
            args_nxt = word[15:0];
            idx_nxt  = 16'd0;
            if (word[15:0] == 16'd0) begin
              if (pos_inc != body_len_r) begin
                fail       = 1'b1;
                fail_cause = CAUSE_TRAIL;
              end else begin
                phase_nxt        = PH_LEN;
                body_pos_nxt     = '0;
                bytes_nxt        = '0;
                emit             = 1'b1;
                res_nxt.kind     = KIND_NOARGS;
                res_nxt.last_msg = 1'b1;
              end
            end else if (body_rem < HDR_LEN) begin
              fail       = 1'b1;
              fail_cause = CAUSE_HDR_OVR;
            end else begin
              phase_nxt = PH_ARGLEN;
            end
          end
        end
      end
      PH_ARGLEN: begin
        body_pos_nxt = pos_inc;
        if (hdr_done) begin
          args_nxt = args_dec;
          end_args = args_dec;
          if (word > 32'(body_rem)) begin
            fail       = 1'b1;
            fail_cause = CAUSE_DATA_OVR;
          end else if (word == 32'd0) begin
            arg_end  = 1'b1;
            end_kind = KIND_EMPTY;
          end else begin
            bytes_nxt = word[LENGTH_BITS-1:0];
            phase_nxt = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        body_pos_nxt = pos_inc;
        bytes_nxt    = bytes_dec;
        if (bytes_dec == '0) begin
          arg_end  = 1'b1;
          end_kind = KIND_BYTE;
          end_byte = step_byte;
        end else begin
          emit              = 1'b1;
          res_nxt.kind      = KIND_BYTE;
          res_nxt.arg_byte  = step_byte;
          res_nxt.arg_index = idx_r;
        end
      end
      PH_DEAD: ;
      default: ;
    endcase

    if (arg_end) begin
      if (end_args == 16'd0) begin
        if (pos_inc != body_len_r) begin
          fail       = 1'b1;
          fail_cause = CAUSE_TRAIL;
        end else begin
          phase_nxt         = PH_LEN;
          hdr_cnt_nxt       = 2'd0;
          body_pos_nxt      = '0;
          args_nxt          = 16'd0;
          bytes_nxt         = '0;
          idx_nxt           = 16'd0;
          emit              = 1'b1;
          res_nxt.kind      = end_kind;
          res_nxt.arg_byte  = end_byte;
          res_nxt.arg_index = idx_r;
          res_nxt.last_arg  = 1'b1;
          res_nxt.last_msg  = 1'b1;
        end
      end else if (body_rem < HDR_LEN) begin
        fail       = 1'b1;
        fail_cause = CAUSE_HDR_OVR;
      end else begin
        idx_nxt           = idx_r + 16'd1;
        phase_nxt         = PH_ARGLEN;
        emit              = 1'b1;
        res_nxt.kind      = end_kind;
        res_nxt.arg_byte  = end_byte;
        res_nxt.arg_index = idx_r;
        res_nxt.last_arg  = 1'b1;
      end
    end

    if (fail) begin
      phase_nxt         = PH_DEAD;
      emit              = 1'b1;
      res_nxt           = '0;
      res_nxt.kind      = KIND_ERROR;
      res_nxt.arg_index = idx_r;
      res_nxt.last_msg  = 1'b1;
      res_nxt.cause     = fail_cause;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEN;
      hdr_cnt_r   <= 2'd0;
      hdr_shift_r <= '0;
      body_len_r  <= '0;
      body_pos_r  <= '0;
      args_r      <= 16'd0;
      bytes_r     <= '0;
      idx_r       <= 16'd0;
      res_vld_r   <= 1'b0;
    end else begin
      if (step_en) begin
        phase_r     <= phase_nxt;
        hdr_cnt_r   <= hdr_cnt_nxt;
        hdr_shift_r <= hdr_shift_nxt;
        body_len_r  <= body_len_nxt;
        body_pos_r  <= body_pos_nxt;
        args_r      <= args_nxt;
        bytes_r     <= bytes_nxt;
        idx_r       <= idx_nxt;
      end
      if (step_en && emit) begin
        res_vld_r <= 1'b1;
      end else if (res_ready) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && emit) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_vld_r;
  assign res       = res_r;

endmodule
